/* design/fpba_pkg.sv */
package fpba_pkg;

   // Table geometry.
   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

   // Fixed field widths of the channels and registers.
   localparam int TYPE_BITS      = 1;
   localparam int BLK_IDX_BITS   = 4;
   localparam int AMOUNT_BITS    = 16;
   localparam int BLKNUM_BITS    = 5;
   localparam int MODE_BITS      = 2;
   localparam int ACTIVE_BITS    = 5;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;

   typedef logic [SIZE_BITS-1:0]   size_type;
   typedef logic [IDX_BITS-1:0]    idx_type;
   typedef logic [CNT_BITS-1:0]    cnt_type;
   typedef logic [MODE_BITS-1:0]   mode_type;
   typedef logic [ACTIVE_BITS-1:0] active_type;

   // Item kinds.
   localparam logic [TYPE_BITS-1:0] REQ_LOAD  = 1'b0;
   localparam logic [TYPE_BITS-1:0] REQ_ALLOC = 1'b1;

   // Placement policies; the unused code behaves as first fit.
   localparam mode_type FIT_FIRST = 2'd0;
   localparam mode_type FIT_BEST  = 2'd1;
   localparam mode_type FIT_WORST = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIT_MODE      = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_BLOCKS = 1'b1;

   // Reset values of the registers.
   localparam mode_type   FIT_MODE_RESET      = FIT_FIRST;
   localparam active_type ACTIVE_BLOCKS_RESET = 5'd16;

endpackage

/* design/fpba_if.sv */
// Request channel: load or allocate items.
interface fpba_req_if;
   import fpba_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [TYPE_BITS-1:0]    req_type;
   logic [BLK_IDX_BITS-1:0] block_index;
   logic [AMOUNT_BITS-1:0]  amount;

   modport source (output valid, output req_type, output block_index, output amount,
                   input ready);
   modport sink   (input valid, input req_type, input block_index, input amount,
                   output ready);
endinterface

// Response channel: one item per allocate request.
interface fpba_rsp_if;
   import fpba_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   granted;
   logic [BLKNUM_BITS-1:0] block_number;
   logic [AMOUNT_BITS-1:0] left_after;

   modport source (output valid, output granted, output block_number, output left_after,
                   input ready);
   modport sink   (input valid, input granted, input block_number, input left_after,
                   output ready);
endinterface

/* design/fit_policy_block_allocator_unit.sv */
// Block allocator with first, best and worst fit placement.
//
// The req channel carries load and allocate items. A load writes the free
// size of one table entry and finishes in the cycle it is accepted. An
// allocate item walks the active entries one per cycle through a single
// comparator, subtracts the request from the chosen entry and returns one
// rsp item with the grant flag, the 1-based block number and the size left.
//
// An allocation scans the active entries (up to 16; first fit stops at
// the first hit), takes one closing scan step when the walk runs to the
// end and then one update step that writes the table and the response
// register; the unit takes no new item until it is back in idle. The
// response sits in an output register; a new item can be accepted while
// it waits, but the next allocation holds in its update cycle until the
// receiver has taken the previous response.
//
// Reset clears the control state and sets fit_mode to first fit and
// active_blocks to 16. Table entries are undefined until loaded.
// The user must write the csr port only while the unit is idle; the unit does not enforce this.
module fit_policy_block_allocator_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   fpba_req_if.sink                                req,
   fpba_rsp_if.source                              rsp,
   input  logic                                    csr_we,
   input  logic [fpba_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [fpba_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import fpba_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   mode_type   mode_ff;
   active_type active_ff;
   cnt_type    cnt_ff, cnt_in;
   logic       found_ff, found_in;
   idx_type    chosen_ff, chosen_in;
   size_type   best_ff, best_in;
   size_type   need_ff, need_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   granted_ff, granted_in;
   logic [BLKNUM_BITS-1:0] blknum_ff, blknum_in;
   logic [AMOUNT_BITS-1:0] left_ff, left_in;

   size_type free_size_ff [NUM_BLOCKS];

   logic     req_fire;
   cnt_type  limit;
   size_type entry;
   logic     fits;
   logic     take;
   logic     out_free;
   size_type remain;
   logic     mem_we;
   idx_type  mem_waddr;
   size_type mem_wdata;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // Number of entries scanned, clamped to the table depth.
   assign limit = (int'(active_ff) > NUM_BLOCKS) ? CNT_BITS'(NUM_BLOCKS)
                                                 : CNT_BITS'(active_ff);

   // The shared comparator looks at one entry per scan cycle.
   assign entry  = free_size_ff[cnt_ff[IDX_BITS-1:0]];
   assign fits   = (entry >= need_ff);
   assign take   = fits && (!found_ff ||
                            ((mode_ff == FIT_BEST)  && (entry < best_ff)) ||
                            ((mode_ff == FIT_WORST) && (entry > best_ff)));
   assign remain = best_ff - need_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= FIT_MODE_RESET;
         active_ff <= ACTIVE_BLOCKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIT_MODE:      mode_ff   <= csr_wdata[MODE_BITS-1:0];
            CSR_ACTIVE_BLOCKS: active_ff <= csr_wdata[ACTIVE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: accept; write a load at once, or scan one entry per cycle for an allocation, then update and respond.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      chosen_in    = chosen_ff;
      best_in      = best_ff;
      need_in      = need_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      granted_in   = granted_ff;
      blknum_in    = blknum_ff;
      left_in      = left_ff;
      mem_we       = 1'b0;
      mem_waddr    = chosen_ff;
      mem_wdata    = remain;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.req_type == REQ_ALLOC) begin
                  need_in  = size_type'(req.amount);
                  cnt_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end else if (int'(req.block_index) < NUM_BLOCKS) begin
                  mem_we    = 1'b1;
                  mem_waddr = IDX_BITS'(req.block_index);
                  mem_wdata = size_type'(req.amount);
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff >= limit) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (take) begin
                  found_in  = 1'b1;
                  chosen_in = cnt_ff[IDX_BITS-1:0];
                  best_in   = entry;
                  // First fit stops at the first entry that holds the request.
                  if (mode_ff != FIT_BEST && mode_ff != FIT_WORST) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               granted_in   = found_ff;
               blknum_in    = found_ff ? BLKNUM_BITS'(int'(chosen_ff) + 1) : '0;
               left_in      = found_ff ? AMOUNT_BITS'(remain) : '0;
               mem_we       = found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         cnt_ff       <= cnt_in;
      end
      chosen_ff  <= chosen_in;
      best_ff    <= best_in;
      need_ff    <= need_in;
      granted_ff <= granted_in;
      blknum_ff  <= blknum_in;
      left_ff    <= left_in;
   end

   // Free size table, undefined until loaded.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         free_size_ff[mem_waddr] <= mem_wdata;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.granted      = granted_ff;
   assign rsp.block_number = blknum_ff;
   assign rsp.left_after   = left_ff;

   // A new response only comes out of the update cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> rsp_valid_ff)
      else $error("response not issued after update");

   // The scan counter never runs past the clamped entry count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= limit))
      else $error("scan counter beyond active entries");

   // A chosen entry always holds the request.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && found_ff) |-> (best_ff >= need_ff))
      else $error("chosen entry smaller than request");

   // A refused request reports block zero and nothing left.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !granted_ff) |-> (blknum_ff == '0 && left_ff == '0))
      else $error("refused response carries a block");

   // A granted request reports a block inside the table.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && granted_ff) |->
         (blknum_ff != '0 && int'(blknum_ff) <= NUM_BLOCKS))
      else $error("granted block number out of range");

endmodule

/* tb/sv/fit_policy_block_allocator_unit_tb.sv */
`timescale 1ns / 100ps

module fit_policy_block_allocator_unit_tb;
   import fpba_pkg::*;

   // The policy code that the package leaves unnamed; it acts as first fit.
   localparam mode_type FIT_SPARE = 2'd3;

   localparam int DRAIN_CYCLES  = 24;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_ITEMS   = 100;
   localparam int QUIET_PHASES  = 3;

   typedef struct packed {
      logic [TYPE_BITS-1:0]    kind;
      logic [BLK_IDX_BITS-1:0] index;
      logic [AMOUNT_BITS-1:0]  amount;
   } alloc_item_type;

   typedef struct packed {
      logic                   granted;
      logic [BLKNUM_BITS-1:0] block_number;
      logic [AMOUNT_BITS-1:0] left_after;
   } grant_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   fpba_req_if req_ch ();
   fpba_rsp_if rsp_ch ();

   fit_policy_block_allocator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the table and the registers.
   size_type    free_left [NUM_BLOCKS];
   mode_type    policy;
   active_type  scan_count;

   alloc_item_type pending_items [$];
   grant_type      grants_due [$];
   alloc_item_type next_item;

   int  issued_count;
   int  accepted_count;
   int  mismatches;
   int  cycle_count;
   int  gap_left;
   int  stall_left;
   bit  idling_on;
   bit  req_fire;

   always #2 clock = ~clock;

   // Applies one accepted item to the shadow table; allocations queue a grant.
   function automatic void apply_item(input alloc_item_type it);
      int        limit;
      int        chosen;
      grant_type g;
      if (it.kind == REQ_LOAD) begin
         free_left[it.index] = it.amount;
         return;
      end
      limit  = (scan_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(scan_count);
      chosen = -1;
      for (int j = 0; j < limit; j++) begin
         if (free_left[j] < it.amount) continue;
         if (chosen < 0) begin
            chosen = j;
            if (policy != FIT_BEST && policy != FIT_WORST) break;
         end else if (policy == FIT_BEST && free_left[j] < free_left[chosen]) begin
            chosen = j;
         end else if (policy == FIT_WORST && free_left[j] > free_left[chosen]) begin
            chosen = j;
         end
      end
      g = '0;
      if (chosen >= 0) begin
         free_left[chosen] = free_left[chosen] - it.amount;
         g.granted      = 1'b1;
         g.block_number = BLKNUM_BITS'(chosen + 1);
         g.left_after   = free_left[chosen];
      end
      grants_due.push_back(g);
   endfunction

   // Sizes lean large for loads and small for requests, with both extremes.
   function automatic logic [AMOUNT_BITS-1:0] rand_amount(input bit for_load);
      logic [AMOUNT_BITS-1:0] v;
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = '1;
         2, 3: v = AMOUNT_BITS'($urandom_range(0, 4095));
         4: v = for_load ? AMOUNT_BITS'($urandom) : AMOUNT_BITS'($urandom_range(1, 255));
         default: v = for_load ? AMOUNT_BITS'($urandom) : AMOUNT_BITS'($urandom_range(0, 255));
      endcase
      return v;
   endfunction

   task automatic add_item(input logic [TYPE_BITS-1:0] kind,
                           input logic [BLK_IDX_BITS-1:0] index,
                           input logic [AMOUNT_BITS-1:0] amount);
      alloc_item_type it;
      it.kind   = kind;
      it.index  = index;
      it.amount = amount;
      pending_items.push_back(it);
      issued_count++;
   endtask

   // Waits until every item is taken and every grant is back, then lets
   // the unit run out any scan still in progress.
   task automatic settle();
      while (accepted_count != issued_count || grants_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only while the unit is idle.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (index == CSR_FIT_MODE)
         policy = mode_type'(value);
      else
         scan_count = active_type'(value);
   endtask

   // Request driver: holds an item until it is taken, with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (gap_left > 0) begin
            req_ch.valid <= 1'b0;
            gap_left--;
         end else if (pending_items.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            gap_left = $urandom_range(0, 8);
         end else begin
            next_item = pending_items.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.req_type    <= next_item.kind;
            req_ch.block_index <= next_item.index;
            req_ch.amount      <= next_item.amount;
         end
      end
   end

   // Response ready with random stall bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = $urandom_range(0, 8);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: predicts on each accepted item, checks each accepted grant.
   always @(posedge clock) begin
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_ch.valid && req_ch.ready;
         if (req_fire) begin
            apply_item({req_ch.req_type, req_ch.block_index, req_ch.amount});
            accepted_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (grants_due.size() == 0) begin
               $error("result item with no allocation pending: granted %0d block %0d left %0d",
                      rsp_ch.granted, rsp_ch.block_number, rsp_ch.left_after);
               mismatches++;
            end else begin
               grant_type g;
               g = grants_due.pop_front();
               if (rsp_ch.granted !== g.granted) begin
                  $error("granted: expected %0d, actual %0d", g.granted, rsp_ch.granted);
                  mismatches++;
               end
               if (rsp_ch.block_number !== g.block_number) begin
                  $error("block_number: expected %0d, actual %0d",
                         g.block_number, rsp_ch.block_number);
                  mismatches++;
               end
               if (rsp_ch.left_after !== g.left_after) begin
                  $error("left_after: expected %0d, actual %0d", g.left_after,
                         rsp_ch.left_after);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fit_policy_block_allocator_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int             ph;
      int             n;
      alloc_item_type it;

      clock              = 1'b0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_LOAD;
      req_ch.block_index = '0;
      req_ch.amount      = '0;
      rsp_ch.ready       = 1'b0;
      policy             = FIT_MODE_RESET;
      scan_count         = ACTIVE_BLOCKS_RESET;
      foreach (free_left[k]) free_left[k] = '0;
      issued_count       = 0;
      accepted_count     = 0;
      mismatches         = 0;
      cycle_count        = 0;
      gap_left           = 0;
      stall_left         = 0;
      idling_on          = 1'b1;
      req_fire           = 1'b0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Load every entry first so that no scan ever reads an unloaded one.
      // Entry 0 is empty, entry 15 holds the largest size.
      for (int k = 0; k < NUM_BLOCKS; k++) begin
         if (k == 0)
            add_item(REQ_LOAD, BLK_IDX_BITS'(k), '0);
         else if (k == NUM_BLOCKS - 1)
            add_item(REQ_LOAD, BLK_IDX_BITS'(k), '1);
         else
            add_item(REQ_LOAD, BLK_IDX_BITS'(k), AMOUNT_BITS'(k * 300));
      end

      // Reset settings: a zero request fits the empty entry, the largest
      // request fits only the full entry, and then nothing fits it.
      add_item(REQ_ALLOC, '0, '0);
      add_item(REQ_ALLOC, '0, '1);
      add_item(REQ_ALLOC, '0, '1);
      add_item(REQ_ALLOC, '0, 16'd4200);
      settle();

      write_register(CSR_FIT_MODE, CSR_DATA_BITS'(FIT_BEST));
      add_item(REQ_ALLOC, '0, 16'd250);
      settle();
      write_register(CSR_FIT_MODE, CSR_DATA_BITS'(FIT_WORST));
      add_item(REQ_ALLOC, '0, 16'd1);
      settle();
      write_register(CSR_FIT_MODE, CSR_DATA_BITS'(FIT_SPARE));
      add_item(REQ_ALLOC, '0, 16'd50);
      settle();
      // No entry scanned at all.
      write_register(CSR_ACTIVE_BLOCKS, '0);
      add_item(REQ_ALLOC, '0, '0);
      settle();
      // A count above the table size; ties under best fit go to the lowest index.
      write_register(CSR_ACTIVE_BLOCKS, '1);
      write_register(CSR_FIT_MODE, CSR_DATA_BITS'(FIT_BEST));
      add_item(REQ_ALLOC, '0, '0);
      settle();
      write_register(CSR_ACTIVE_BLOCKS, CSR_DATA_BITS'(1));
      write_register(CSR_FIT_MODE, CSR_DATA_BITS'(FIT_FIRST));
      add_item(REQ_ALLOC, '0, 16'd1);
      settle();

      // Random phases, each under fresh settings; the last ones run without idling.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph >= RANDOM_PHASES - QUIET_PHASES)
            idling_on = 1'b0;
         write_register(CSR_FIT_MODE, CSR_DATA_BITS'($urandom_range(0, 3)));
         case ($urandom_range(0, 7))
            0: n = 0;
            1: n = 1;
            2: n = NUM_BLOCKS;
            3: n = $urandom_range(NUM_BLOCKS + 1, 31);
            default: n = $urandom_range(2, NUM_BLOCKS - 1);
         endcase
         write_register(CSR_ACTIVE_BLOCKS, CSR_DATA_BITS'(n));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            it.kind   = ($urandom_range(0, 9) < 4) ? REQ_LOAD : REQ_ALLOC;
            it.index  = BLK_IDX_BITS'($urandom_range(0, NUM_BLOCKS - 1));
            it.amount = rand_amount(it.kind == REQ_LOAD);
            add_item(it.kind, it.index, it.amount);
         end
         settle();
      end

      if (mismatches == 0)
         $display("fit_policy_block_allocator_unit_tb: done, clean");
      else
         $display("fit_policy_block_allocator_unit_tb: done, errors");
      $finish;
   end

endmodule
